FILE: rtl/fla_pkg.sv
// Package for the free-list slot allocator.
// Holds sizes, status and opcode encodings, FSM states and shared structs.
// No dependencies.
package fla_pkg;

  // Pool geometry.
  localparam int NODES_PER_POOL = 64;
  localparam int MAX_POOLS      = 16;

  // Slot space and counter widths.
  localparam int SLOT_W     = 10;
  localparam int SLOT_SPACE = 1 << SLOT_W;
  localparam int CNT_W      = SLOT_W + 1;
  localparam int POOL_OUT_W = 5;
  localparam int POOL_W     = $clog2(MAX_POOLS + 1);
  localparam int LIMIT_W    = $clog2(MAX_POOLS * NODES_PER_POOL + 1);
  localparam int CMP_W      = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [POOL_W-1:0]     pool_t;
  typedef logic [LIMIT_W-1:0]    limit_t;
  typedef logic [POOL_OUT_W-1:0] pool_out_t;

  // Request opcode.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_BAD_HANDLE = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_t;

  // Access to the link memory.
  typedef struct packed {
    logic  re;
    slot_t raddr;
    logic  we;
    slot_t waddr;
    slot_t wdata;
  } mem_req_t;

  // One result item.
  typedef struct packed {
    slot_t     slot;
    status_t   status;
    cnt_t      used;
    pool_out_t pools;
  } result_t;

endpackage

FILE: rtl/fla_link_ram.sv
// Next-link memory of the freed-slot list: one write and one read port.
// Read data is registered. Depends on fla_pkg.
module fla_link_ram
  import fla_pkg::*;
(
  input  logic     clk,
  input  mem_req_t mem_req,
  output slot_t    rdata
);

  slot_t mem [SLOT_SPACE];
  slot_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rdata_r <= mem[mem_req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/fla_ctrl.sv
// Allocator control: request capture, list head and counters, and the
// two-state sequencer around the link memory. Depends on fla_pkg.
module fla_ctrl
  import fla_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_op,
  input  slot_t    in_slot_in,
  input  logic     out_space,
  output mem_req_t mem_req,
  input  slot_t    mem_rdata,
  output logic     done,
  output result_t  result
);

  fsm_t   state_r, state_nxt;
  op_t    op_r;
  slot_t  slot_r;
  slot_t  free_head_r, free_head_nxt;
  logic   free_nonempty_r, free_nonempty_nxt;
  cnt_t   fresh_next_r, fresh_next_nxt;
  pool_t  pools_open_r, pools_open_nxt;
  limit_t pool_end_r, pool_end_nxt;
  cnt_t   in_use_r, in_use_nxt;
  logic   accept;
  logic   link_we;

  assign accept = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_space) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    done     = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_EXEC:  done     = out_space;
      default: in_ready = 1'b0;
    endcase
  end

  // Request execution: pop, fresh grant or push, computed from the
  // registered request and the link read issued on acceptance.
  always_comb begin
    free_head_nxt     = free_head_r;
    free_nonempty_nxt = free_nonempty_r;
    fresh_next_nxt    = fresh_next_r;
    pools_open_nxt    = pools_open_r;
    pool_end_nxt      = pool_end_r;
    in_use_nxt        = in_use_r;
    link_we           = 1'b0;
    result.slot       = '0;
    result.status     = ST_OK;
    if (op_r == OP_ALLOC) begin
      if (in_use_r < cnt_t'(SLOT_SPACE)) begin
        in_use_nxt = in_use_r + cnt_t'(1);
      end
      if (free_nonempty_r) begin
        // Pop the most recently freed slot.
        result.slot       = free_head_r;
        free_head_nxt     = mem_rdata;
        free_nonempty_nxt = (in_use_nxt < fresh_next_r);
      end else if (fresh_next_r >= cnt_t'(SLOT_SPACE)) begin
        in_use_nxt    = in_use_r;
        result.status = ST_EXHAUSTED;
      end else if (CMP_W'(fresh_next_r) >= CMP_W'(pool_end_r) &&
                   pools_open_r >= pool_t'(MAX_POOLS)) begin
        in_use_nxt    = in_use_r;
        result.status = ST_EXHAUSTED;
      end else begin
        // Grant the next never-issued slot, opening a pool if needed.
        if (CMP_W'(fresh_next_r) >= CMP_W'(pool_end_r)) begin
          pools_open_nxt = pools_open_r + pool_t'(1);
          pool_end_nxt   = pool_end_r + limit_t'(NODES_PER_POOL);
        end
        result.slot    = fresh_next_r[SLOT_W-1:0];
        fresh_next_nxt = fresh_next_r + cnt_t'(1);
      end
    end else begin
      if (cnt_t'(slot_r) >= fresh_next_r) begin
        result.status = ST_BAD_HANDLE;
      end else begin
        // Push the slot onto the freed list.
        link_we           = 1'b1;
        free_head_nxt     = slot_r;
        free_nonempty_nxt = 1'b1;
        if (in_use_r != '0) begin
          in_use_nxt = in_use_r - cnt_t'(1);
        end
      end
    end
    result.used  = in_use_nxt;
    result.pools = pool_out_t'(pools_open_nxt);
  end

  // Link memory access: read the head on acceptance, write on a push.
  always_comb begin
    mem_req.re    = accept;
    mem_req.raddr = free_head_r;
    mem_req.we    = done && link_we;
    mem_req.waddr = slot_r;
    mem_req.wdata = free_head_r;
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_op);
      slot_r <= in_slot_in;
    end
  end

  // Sequencer and allocator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      free_head_r     <= '0;
      free_nonempty_r <= 1'b0;
      fresh_next_r    <= '0;
      pools_open_r    <= '0;
      pool_end_r      <= '0;
      in_use_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (done) begin
        free_head_r     <= free_head_nxt;
        free_nonempty_r <= free_nonempty_nxt;
        fresh_next_r    <= fresh_next_nxt;
        pools_open_r    <= pools_open_nxt;
        pool_end_r      <= pool_end_nxt;
        in_use_r        <= in_use_nxt;
      end
    end
  end

endmodule

FILE: rtl/free_list_slot_allocator_top.sv
// A result is registered in the output register from the execute state, once the
// output register has room; while it is full, the request waits in that state.
// A new request is taken only after the last one resolves; the link memory read
// of the list head, issued at the transfer, must return before it resolves.
// The next request is taken while a result waits in the output register.
// Reset (synchronous, rst_n low) empties the freed list and all counters;
// the link memory is not cleared and needs no clearing pass.
module free_list_slot_allocator_top
  import fla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [SLOT_W-1:0]     in_slot_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SLOT_W-1:0]     out_slot_out,
  output logic [1:0]            out_status,
  output logic [CNT_W-1:0]      out_used_count,
  output logic [POOL_OUT_W-1:0] out_pool_count
);

  mem_req_t mem_req;
  slot_t    mem_rdata;
  logic     done;
  logic     out_space;
  result_t  result;
  result_t  out_data_r;
  logic     out_valid_r;

  // The output register can take a result when empty or being drained.
  assign out_space = !out_valid_r || out_ready;

  fla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_slot_in (in_slot_in),
    .out_space  (out_space),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .done       (done),
    .result     (result)
  );

  fla_link_ram u_link_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot_out   = out_data_r.slot;
  assign out_status     = out_data_r.status;
  assign out_used_count = out_data_r.used;
  assign out_pool_count = out_data_r.pools;

  // A refused request never carries a slot.
  a_refused_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_slot_out == '0)
    else $error("refused request reports a nonzero slot");

  // The allocated count never exceeds the slot space.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_used_count <= CNT_W'(SLOT_SPACE))
    else $error("used count beyond slot space");

  // Requests are taken one at a time: no transfer right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a request is in flight");

  // A result is only loaded when the output register has room.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

endmodule

FILE: dv/tb_free_list_slot_allocator_top.sv
// Testbench for free_list_slot_allocator_top: random and directed allocate/free requests
// checked against a built-in predictor of the freed-slot list and the pool counters.
// Depends on fla_pkg and the allocator RTL only.
module tb_free_list_slot_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fla_pkg::*;

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      in_valid   = 1'b0;
  logic      in_ready;
  logic      in_op      = OP_ALLOC;
  slot_t     in_slot_in = '0;
  logic      out_valid;
  logic      out_ready  = 1'b0;
  slot_t     out_slot_out;
  logic [1:0] out_status;
  cnt_t      out_used_count;
  pool_out_t out_pool_count;

  free_list_slot_allocator_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_slot_in    (in_slot_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_slot_out  (out_slot_out),
    .out_status    (out_status),
    .out_used_count(out_used_count),
    .out_pool_count(out_pool_count)
  );

  always #1 clk = ~clk;

  // Predicted allocator state: link memory, freed-list head and counters.
  slot_t link_mem [SLOT_SPACE];
  slot_t list_head    = '0;
  logic  list_live    = 1'b0;
  int    fresh_ptr    = 0;
  int    pools_opened = 0;
  int    slots_used   = 0;

  // Responses still owed by the block, and slots the stimulus believes are held.
  result_t pending_resp_q [$];
  slot_t   held_slots [$];
  int      exhausted_cnt = 0;
  int      err_cnt       = 0;

  // Idle percentages and receiver hold-off requests.
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_len     = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  // Work out the response to one request and advance the predicted state.
  function automatic result_t predict_response(op_t op, slot_t slot);
    result_t r;
    r.slot   = '0;
    r.status = ST_OK;
    if (op == OP_ALLOC) begin
      if (list_live) begin
        // Pop the most recently freed slot.
        r.slot    = list_head;
        list_head = link_mem[r.slot];
        if (slots_used < SLOT_SPACE) slots_used++;
        list_live = slots_used < fresh_ptr;
      end else if (fresh_ptr >= SLOT_SPACE) begin
        r.status = ST_EXHAUSTED;
      end else if (fresh_ptr >= pools_opened * NODES_PER_POOL &&
                   pools_opened >= MAX_POOLS) begin
        r.status = ST_EXHAUSTED;
      end else begin
        // Hand out a never-issued slot, opening a pool when the newest is used up.
        if (fresh_ptr >= pools_opened * NODES_PER_POOL) pools_opened++;
        r.slot = slot_t'(fresh_ptr);
        fresh_ptr++;
        if (slots_used < SLOT_SPACE) slots_used++;
      end
    end else if (int'(slot) >= fresh_ptr) begin
      r.status = ST_BAD_HANDLE;
    end else begin
      // Push the freed slot onto the list.
      link_mem[slot] = list_head;
      list_head      = slot;
      list_live      = 1'b1;
      if (slots_used > 0) slots_used--;
    end
    r.used  = cnt_t'(slots_used);
    r.pools = pool_out_t'(pools_opened);
    return r;
  endfunction

  // Offer one request, record its predicted response, and wait for the transfer.
  task automatic issue_request(op_t op, slot_t slot);
    result_t r;
    int      idx;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_slot_in <= slot;
    r = predict_response(op, slot);
    pending_resp_q.push_back(r);
    if (r.status == ST_EXHAUSTED) begin
      exhausted_cnt++;
    end else if (op == OP_ALLOC && r.status == ST_OK) begin
      held_slots.push_back(r.slot);
    end else if (op == OP_FREE && r.status == ST_OK) begin
      idx = -1;
      foreach (held_slots[i]) if (held_slots[i] == slot) idx = i;
      if (idx >= 0) held_slots.delete(idx);
    end
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly frees of held slots, some double frees and some arbitrary handles.
  function automatic slot_t pick_free_slot();
    int roll;
    roll = $urandom_range(0, 99);
    if (held_slots.size() != 0 && roll < 80)
      return held_slots[$urandom_range(0, held_slots.size() - 1)];
    if (fresh_ptr != 0 && roll < 92)
      return slot_t'($urandom_range(0, fresh_ptr - 1));
    return slot_t'($urandom);
  endfunction

  task automatic random_request(int alloc_pct);
    if ($urandom_range(0, 99) < alloc_pct) begin
      issue_request(OP_ALLOC, slot_t'($urandom));
    end else begin
      issue_request(OP_FREE, pick_free_slot());
    end
  endtask

  // Stop offering and wait until every predicted response has arrived.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Bad handles at reset, first grants, double frees and pops of a repeated slot.
  task automatic test_directed();
    issue_request(OP_FREE, slot_t'(0));
    issue_request(OP_FREE, slot_t'(SLOT_SPACE - 1));
    issue_request(OP_ALLOC, slot_t'(SLOT_SPACE - 1));
    issue_request(OP_ALLOC, slot_t'(0));
    issue_request(OP_FREE, slot_t'(2));
    issue_request(OP_FREE, slot_t'(10'h2AA));
    issue_request(OP_FREE, slot_t'(10'h155));
    issue_request(OP_FREE, slot_t'(1));
    issue_request(OP_FREE, slot_t'(1));
    issue_request(OP_FREE, slot_t'(0));
    issue_request(OP_FREE, slot_t'(0));
    issue_request(OP_ALLOC, slot_t'(10'h155));
    issue_request(OP_ALLOC, slot_t'(10'h2AA));
    issue_request(OP_ALLOC, slot_t'(0));
    repeat (4) issue_request(OP_ALLOC, slot_t'($urandom));
    issue_request(OP_FREE, slot_t'(3));
    issue_request(OP_FREE, slot_t'(5));
    issue_request(OP_ALLOC, slot_t'(0));
    issue_request(OP_ALLOC, slot_t'(0));
    issue_request(OP_ALLOC, slot_t'(0));
  endtask

  task automatic test_random_churn(int count, int alloc_pct);
    repeat (count) random_request(alloc_pct);
  endtask

  // Allocation-heavy traffic through every pool until the slot space runs out.
  task automatic test_fill_to_exhaustion();
    int target;
    int guard;
    target = exhausted_cnt + 12;
    guard  = 0;
    while (exhausted_cnt < target && guard < 4000) begin
      random_request(92);
      guard++;
    end
  endtask

  // Hold the result side off long enough that the block stalls its input.
  task automatic test_backpressure();
    hold_len = 80;
    hold_req++;
    repeat (12) random_request(50);
    wait_for_drain();
  endtask

  // Result side: random or held-off ready.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // Compare each result transfer with the oldest predicted response.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_resp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual slot %0d status %0d",
                 $time, out_slot_out, out_status);
        err_cnt++;
      end else begin
        want = pending_resp_q.pop_front();
        check_field("slot_out", want.slot, out_slot_out);
        check_field("status", want.status, out_status);
        check_field("used_count", want.used, out_used_count);
        check_field("pool_count", want.pools, out_pool_count);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    snd_idle_pct = 16;
    rcv_idle_pct = 73;
    test_directed();
    test_random_churn(200, 55);
    test_backpressure();

    // Sender idles heavily, receiver lightly.
    snd_idle_pct = 73;
    rcv_idle_pct = 16;
    test_fill_to_exhaustion();
    wait_for_drain();

    // No idling on either side.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_churn(250, 50);
    test_backpressure();

    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[free_list_slot_allocator_top] OK");
    end else begin
      $display("[free_list_slot_allocator_top] ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("[free_list_slot_allocator_top] ERROR");
    $finish;
  end

endmodule
